// ===== sv/rmgm_pkg.sv =====
`timescale 1ns / 1ps
package rmgm_pkg;

    // Default sizing of the region table and the byte pool
    localparam int MAX_REGIONS_DEF = 16;
    localparam int POOL_SIZE_DEF   = 65536;

    // Field widths
    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 17;
    localparam int DATA_W  = 64;

    // Stream payload widths
    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_MAP   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Access width codes
    localparam logic [1:0] AW_BYTE = 2'd0;
    localparam logic [1:0] AW_HALF = 2'd1;
    localparam logic [1:0] AW_WORD = 2'd2;
    localparam logic [1:0] AW_DWORD = 2'd3;

endpackage

// ===== sv/rmgm_ram.sv =====
`timescale 1ns / 1ps
module rmgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/region_mapped_guest_memory_unit.sv =====
`timescale 1ns / 1ps
// Guest memory built from up to MAX_REGIONS mapped regions whose bytes come from a
// bump-allocated pool of POOL_SIZE bytes. After reset the block clears the pool, one
// byte a cycle, and takes no transfer until done. Each item then runs on one shared
// region-table scanner: every address lookup walks the table one entry a cycle, then
// passes through a check state. A map of nonzero size does up to two lookups; a read
// does one lookup (two for a doubleword) plus an issue and a wait state per byte for
// the pool port; a write does one lookup per byte (up to eight). One item is in flight
// at a time; s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register, so the next item is taken while it waits.
module region_mapped_guest_memory_unit #(
    parameter int MAX_REGIONS = rmgm_pkg::MAX_REGIONS_DEF,
    parameter int POOL_SIZE   = rmgm_pkg::POOL_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address[63:0], region_size[80:64], access_width[82:81], write_data[146:83]
    input  logic [rmgm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [rmgm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // map_ok[0], read_data[64:1]
    output logic [rmgm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import rmgm_pkg::*;

    localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int PW = $clog2(POOL_SIZE);
    localparam int IW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Latched item
    func_t              func_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [1:0]         aw_reg;
    logic [DATA_W-1:0]  wdata_reg;

    // Region table
    logic [ADDR_W-1:0]  base_reg  [MAX_REGIONS];
    logic [SIZE_W-1:0]  len_reg   [MAX_REGIONS];
    logic [PW-1:0]      poff_reg  [MAX_REGIONS];
    logic               valid_reg [MAX_REGIONS];
    logic [PW:0]        next_free_reg;

    // Scanner
    logic [ADDR_W-1:0]  look_reg;
    logic [RW-1:0]      scan_reg;
    logic               best_found_reg;
    logic [ADDR_W-1:0]  best_base_reg;
    logic [RW-1:0]      best_idx_reg;
    logic               free_found_reg;
    logic [RW-1:0]      free_idx_reg;

    // Sequencer counters and results
    logic               phase_reg;
    logic [2:0]         step_reg;
    logic [1:0]         byte_reg;
    logic [PW-1:0]      rd_idx_reg;
    logic [PW-1:0]      clr_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic               map_ok_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Pool port
    logic               ram_we;
    logic [PW-1:0]      ram_addr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    // Combinational helpers
    logic               cand;
    logic               better;
    logic [ADDR_W-1:0]  off;
    logic               hit;
    logic [IW-1:0]      idx_wide;
    logic [PW-1:0]      pool_idx;
    logic [1:0]         rd_last;
    logic               rd_fits;
    logic [2:0]         wr_last;
    logic [IW-1:0]      alloc_end;
    logic               in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Table entry under the scanner
    assign cand   = valid_reg[scan_reg] && (base_reg[scan_reg] <= look_reg);
    assign better = cand && (!best_found_reg || (base_reg[scan_reg] > best_base_reg));

    // Bound check on the best candidate
    assign off      = look_reg - best_base_reg;
    assign hit      = best_found_reg && (off[ADDR_W-1:SIZE_W] == '0)
                      && (off[SIZE_W-1:0] < len_reg[best_idx_reg]);
    assign idx_wide = IW'(poff_reg[best_idx_reg]) + IW'(off[SIZE_W-1:0]);
    assign pool_idx = idx_wide[PW-1:0];

    assign rd_last  = (aw_reg == AW_BYTE) ? 2'd0 : ((aw_reg == AW_HALF) ? 2'd1 : 2'd3);
    assign rd_fits  = ((SIZE_W+1)'(off[SIZE_W-1:0]) + (SIZE_W+1)'(rd_last))
                      < {1'b0, len_reg[best_idx_reg]};
    assign wr_last  = 3'((4'd1 << aw_reg) - 4'd1);
    assign alloc_end = IW'(next_free_reg) + IW'(size_reg);

    // Drive the pool port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = rd_idx_reg;
        ram_wdata = wdata_reg[{step_reg, 3'b000} +: 8];
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 8'h00;
            end
            ST_CHECK:
            begin
                ram_we   = (func_reg == FUNC_WRITE) && hit;
                ram_addr = pool_idx;
            end
            default:
            begin
                ram_addr = rd_idx_reg;
            end
        endcase
    end

    rmgm_ram #(
        .WIDTH (8),
        .DEPTH (POOL_SIZE)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            func_reg       <= FUNC_NONE;
            addr_reg       <= '0;
            size_reg       <= '0;
            aw_reg         <= '0;
            wdata_reg      <= '0;
            next_free_reg  <= '0;
            look_reg       <= '0;
            scan_reg       <= '0;
            best_found_reg <= 1'b0;
            best_base_reg  <= '0;
            best_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            phase_reg      <= 1'b0;
            step_reg       <= '0;
            byte_reg       <= '0;
            rd_idx_reg     <= '0;
            clr_reg        <= '0;
            rd_data_reg    <= '0;
            map_ok_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            for (int i = 0; i < MAX_REGIONS; i++)
            begin
                base_reg[i]  <= '0;
                len_reg[i]   <= '0;
                poff_reg[i]  <= '0;
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            // Drop the result once the sink takes the transfer
            if (m_valid_reg && m_axis_tready && (state_reg != ST_DONE))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PW'(POOL_SIZE - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        func_reg       <= func_t'(s_axis_tuser[1:0]);
                        addr_reg       <= s_axis_tdata[63:0];
                        size_reg       <= s_axis_tdata[80:64];
                        aw_reg         <= s_axis_tdata[82:81];
                        wdata_reg      <= s_axis_tdata[146:83];
                        look_reg       <= s_axis_tdata[63:0];
                        scan_reg       <= '0;
                        best_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        phase_reg      <= 1'b0;
                        step_reg       <= '0;
                        rd_data_reg    <= '0;
                        map_ok_reg     <= 1'b0;
                        if ((func_t'(s_axis_tuser[1:0]) == FUNC_NONE)
                            || ((func_t'(s_axis_tuser[1:0]) == FUNC_MAP)
                                && (s_axis_tdata[80:64] == '0)))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    // Track the greatest base at or below the lookup address
                    if (better)
                    begin
                        best_found_reg <= 1'b1;
                        best_base_reg  <= base_reg[scan_reg];
                        best_idx_reg   <= scan_reg;
                    end
                    // Track the first free slot
                    if (!valid_reg[scan_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= scan_reg;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == RW'(MAX_REGIONS - 1))
                    begin
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    scan_reg       <= '0;
                    best_found_reg <= 1'b0;
                    free_found_reg <= 1'b0;
                    case (func_reg)
                        FUNC_MAP:
                        begin
                            if (hit)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else if (!phase_reg)
                            begin
                                // Look up the last byte of the new region
                                phase_reg <= 1'b1;
                                look_reg  <= addr_reg + ADDR_W'(size_reg) - 64'd1;
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                if (free_found_reg && (alloc_end <= IW'(POOL_SIZE)))
                                begin
                                    base_reg[free_idx_reg]  <= addr_reg;
                                    len_reg[free_idx_reg]   <= size_reg;
                                    poff_reg[free_idx_reg]  <= next_free_reg[PW-1:0];
                                    valid_reg[free_idx_reg] <= 1'b1;
                                    next_free_reg           <= alloc_end[PW:0];
                                    map_ok_reg              <= 1'b1;
                                end
                                state_reg <= ST_DONE;
                            end
                        end

                        FUNC_READ:
                        begin
                            if (hit && rd_fits)
                            begin
                                rd_idx_reg <= pool_idx;
                                byte_reg   <= '0;
                                state_reg  <= ST_RD_ISSUE;
                            end
                            else if (!phase_reg && (aw_reg == AW_DWORD))
                            begin
                                phase_reg <= 1'b1;
                                look_reg  <= addr_reg + 64'd4;
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end

                        FUNC_WRITE:
                        begin
                            // Byte was stored through the pool port this cycle if the lookup hit
                            if (step_reg == wr_last)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                step_reg  <= step_reg + 1'b1;
                                look_reg  <= addr_reg + ADDR_W'(step_reg) + 64'd1;
                                state_reg <= ST_SCAN;
                            end
                        end

                        default:
                        begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end

                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end

                ST_RD_WAIT:
                begin
                    // Place the byte in its lane of the result
                    rd_data_reg[{phase_reg, byte_reg, 3'b000} +: 8] <= ram_rdata;
                    if (byte_reg != rd_last)
                    begin
                        byte_reg   <= byte_reg + 1'b1;
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= ST_RD_ISSUE;
                    end
                    else if (!phase_reg && (aw_reg == AW_DWORD))
                    begin
                        phase_reg <= 1'b1;
                        look_reg  <= addr_reg + 64'd4;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    // Hand the result over once the output register is free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {7'b0, rd_data_reg, map_ok_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A result never carries both a map success and read data
    a_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[64:1] != '0)))
        else $error("map_ok and read_data both set");

    // Pool allocation never passes the pool end
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg <= (PW+1)'(POOL_SIZE)))
        else $error("pool allocation past end");

    // A found candidate always names a live region
    a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CHECK) && best_found_reg) |-> valid_reg[best_idx_reg])
        else $error("best candidate not valid");

    // Only a map item reports success
    a_ok_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!map_ok_reg || (func_reg == FUNC_MAP)))
        else $error("map_ok on non-map item");

    // A successful map bumps the pool allocator
    a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(map_ok_reg) |-> (next_free_reg != $past(next_free_reg)))
        else $error("map succeeded without allocation");

endmodule

// ===== bench/tb_region_mapped_guest_memory_unit.sv =====
`timescale 1ns / 1ps
module tb_region_mapped_guest_memory_unit;
    import rmgm_pkg::*;

    localparam int NREG = MAX_REGIONS_DEF;
    localparam int POOL = POOL_SIZE_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    region_mapped_guest_memory_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct packed {
        logic [63:0] read_data;
        logic        map_ok;
    } mem_result_t;

    // Shadow copy of the guest memory
    logic [63:0] shadow_base [NREG];
    logic [16:0] shadow_len  [NREG];
    logic [16:0] shadow_off  [NREG];
    logic        shadow_valid[NREG];
    logic [16:0] shadow_next_free;
    logic [7:0]  shadow_pool [POOL];

    mem_result_t expected_results[$];
    int          mismatch_count;
    int          result_count;
    int          item_count;
    int          map_ok_count;
    longint      cycle_count;
    bit          allow_idle;

    // Region holding addr, or -1
    function automatic int lookup_region(logic [63:0] addr);
        int best;
        best = -1;
        for (int i = 0; i < NREG; i++)
            if (shadow_valid[i] && shadow_base[i] <= addr)
                if (best < 0 || shadow_base[i] > shadow_base[best])
                    best = i;
        if (best < 0)
            return -1;
        if (addr - shadow_base[best] < 64'(shadow_len[best]))
            return best;
        return -1;
    endfunction

    function automatic logic [31:0] read_bytes(logic [63:0] addr, int n);
        int          r;
        logic [63:0] off;
        logic [63:0] idx;
        logic [31:0] v;
        v = '0;
        r = lookup_region(addr);
        if (r < 0)
            return '0;
        off = addr - shadow_base[r];
        if (off + 64'(n - 1) >= 64'(shadow_len[r]))
            return '0;
        for (int i = 0; i < n; i++)
        begin
            idx = 64'(shadow_off[r]) + off + 64'(i);
            if (idx < 64'(POOL))
                v[8*i +: 8] = shadow_pool[idx];
        end
        return v;
    endfunction

    function automatic logic map_region(logic [63:0] base, logic [16:0] size);
        int slot;
        slot = -1;
        if (size == 0)
            return 1'b0;
        if (lookup_region(base) >= 0 || lookup_region(base + 64'(size - 17'd1)) >= 0)
            return 1'b0;
        for (int i = 0; i < NREG; i++)
            if (!shadow_valid[i] && slot < 0)
                slot = i;
        if (slot < 0)
            return 1'b0;
        if (32'(shadow_next_free) + 32'(size) > 32'(POOL))
            return 1'b0;
        shadow_base[slot]  = base;
        shadow_len[slot]   = size;
        shadow_off[slot]   = shadow_next_free;
        shadow_valid[slot] = 1'b1;
        shadow_next_free   = shadow_next_free + size;
        return 1'b1;
    endfunction

    // Apply one item to the shadow memory and return its result
    function automatic mem_result_t predict_access(func_t fn, logic [63:0] addr,
                                                   logic [16:0] size, logic [1:0] aw,
                                                   logic [63:0] wdata);
        mem_result_t res;
        int          r;
        logic [63:0] a;
        logic [63:0] idx;
        res = '0;
        case (fn)
            FUNC_MAP:
                res.map_ok = map_region(addr, size);
            FUNC_READ:
                if (aw == AW_DWORD)
                    res.read_data = {read_bytes(addr + 64'd4, 4), read_bytes(addr, 4)};
                else
                    res.read_data = 64'(read_bytes(addr, 1 << aw));
            FUNC_WRITE:
                for (int i = 0; i < (1 << aw); i++)
                begin
                    a = addr + 64'(i);
                    r = lookup_region(a);
                    if (r >= 0)
                    begin
                        idx = 64'(shadow_off[r]) + (a - shadow_base[r]);
                        if (idx < 64'(POOL))
                            shadow_pool[idx] = wdata[8*i +: 8];
                    end
                end
            default: ;
        endcase
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one item, with random idle bursts ahead of it
    task automatic send_item(func_t fn, logic [63:0] addr, logic [16:0] size,
                             logic [1:0] aw, logic [63:0] wdata);
        int gap;
        if (allow_idle && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(14, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {5'd0, wdata, aw, size, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(predict_access(fn, addr, size, aw, wdata));
        item_count++;
    endtask

    // Receiver stall bursts
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (allow_idle && $urandom_range(3) == 0)
            begin
                gap = $urandom_range(14, 1);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        mem_result_t exp_r;
        mem_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[64:0];
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: map_ok %0d read_data %h",
                             got.map_ok, got.read_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                result_count++;
                if (exp_r.map_ok)
                    map_ok_count++;
                if (got.map_ok !== exp_r.map_ok || got.read_data !== exp_r.read_data)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: map_ok exp %0d got %0d, read_data exp %h got %h",
                                 exp_r.map_ok, got.map_ok, exp_r.read_data,
                                 got.read_data);
                end
            end
        end
    end

    function automatic logic [1:0] rand_aw();
        return 2'($urandom_range(3));
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Edge cases: empty memory, zero size, wrap, enclosing overlap, top of space
    task automatic test_directed();
        send_item(FUNC_READ, 64'h0, 17'd0, AW_DWORD, 64'h0);
        send_item(FUNC_NONE, '1, '1, 2'b11, '1);
        send_item(FUNC_MAP, 64'h1000, 17'd0, AW_BYTE, 64'h0);
        send_item(FUNC_MAP, 64'hFFFF_FFFF_FFFF_FFF8, 17'd16, AW_BYTE, 64'h0);
        send_item(FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFC, 17'd0, AW_DWORD, '1);
        send_item(FUNC_READ, 64'hFFFF_FFFF_FFFF_FFFC, 17'd0, AW_DWORD, 64'h0);
        send_item(FUNC_READ, 64'h4, 17'd0, AW_WORD, 64'h0);
        send_item(FUNC_MAP, 64'h1000, 17'd64, AW_BYTE, 64'h0);
        send_item(FUNC_MAP, 64'h1020, 17'd8, AW_BYTE, 64'h0);
        send_item(FUNC_MAP, 64'h0F00, 17'd1024, AW_BYTE, 64'h0);
        send_item(FUNC_MAP, 64'h0FF0, 17'd32, AW_BYTE, 64'h0);
        send_item(FUNC_WRITE, 64'h1004, 17'd0, AW_DWORD, 64'h0123_4567_89AB_CDEF);
        send_item(FUNC_READ, 64'h1004, 17'd0, AW_DWORD, 64'h0);
        send_item(FUNC_READ, 64'h1005, 17'd0, AW_HALF, 64'h0);
        send_item(FUNC_READ, 64'h1006, 17'd0, AW_BYTE, 64'h0);
        send_item(FUNC_READ, 64'h103E, 17'd0, AW_WORD, 64'h0);
        send_item(FUNC_READ, 64'h1100, 17'd0, AW_WORD, 64'h0);
        send_item(FUNC_WRITE, 64'h103C, 17'd0, AW_DWORD, 64'hA5A5_5A5A_F00F_0FF0);
        send_item(FUNC_READ, 64'h1038, 17'd0, AW_DWORD, 64'h0);
        send_item(FUNC_MAP, 64'h8000_0000_0000_0000, 17'd65536, AW_BYTE, 64'h0);
        send_item(FUNC_MAP, 64'h2000, 17'd1, AW_BYTE, 64'h0);
    endtask

    // Maps, reads, writes and no-op items in random mix, many near earlier regions
    task automatic test_random(int n);
        logic [63:0] addr;
        logic [16:0] size;
        int          pick;
        int          r;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            r = $urandom_range(NREG - 1);
            if (shadow_valid[r])
                addr = shadow_base[r] + 64'($urandom_range(shadow_len[r] + 8)) - 64'd4;
            else
                addr = rand64();
            if (pick < 12)
            begin
                if ($urandom_range(9) == 0)
                    size = 17'($urandom_range(65536));
                else
                    size = 17'($urandom_range(200, 1));
                if ($urandom_range(2) == 0)
                    addr = rand64();
                send_item(FUNC_MAP, addr, size, rand_aw(), rand64());
            end
            else if (pick < 55)
                send_item(FUNC_READ, addr, 17'($urandom()), rand_aw(), rand64());
            else if (pick < 96)
                send_item(FUNC_WRITE, addr, 17'($urandom()), rand_aw(), rand64());
            else
                send_item(FUNC_NONE, rand64(), 17'($urandom()), rand_aw(), rand64());
        end
    endtask

    // Fill the table and the pool, then try more maps
    task automatic test_exhaustion();
        for (int k = 0; k < 20; k++)
            send_item(FUNC_MAP, {$urandom(), 32'h0}, 17'd65536, AW_BYTE, 64'h0);
        for (int k = 0; k < 20; k++)
            send_item(FUNC_MAP, {$urandom(), 32'h1_0000}, 17'($urandom_range(4096, 1)),
                      AW_BYTE, 64'h0);
    endtask

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        result_count   = 0;
        item_count     = 0;
        map_ok_count   = 0;
        allow_idle     = 1'b1;
        shadow_next_free = '0;
        for (int i = 0; i < NREG; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_base[i]  = '0;
            shadow_len[i]   = '0;
            shadow_off[i]   = '0;
        end
        for (int i = 0; i < POOL; i++)
            shadow_pool[i] = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(600);
        test_exhaustion();
        allow_idle = 1'b0;
        test_random(160);
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d items, checked %0d results, %0d successful maps, %0d mismatches",
                 item_count, result_count, map_ok_count, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rmgm_pkg.sv
sv/rmgm_ram.sv
sv/region_mapped_guest_memory_unit.sv
bench/tb_region_mapped_guest_memory_unit.sv
